// ----- src/linked_car_chain_table_unit_defines.svh -----
// assertion macros for the linked car chain table checker
// needs clk and rst_n in scope at the point of use
`ifndef LINKED_CAR_CHAIN_TABLE_UNIT_DEFINES_SVH
`define LINKED_CAR_CHAIN_TABLE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle
`define LCCT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcct check failed");

// consequent must hold in the following cycle
`define LCCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcct check failed");

`endif

// ----- src/lcct_pkg.sv -----
// shared types, codes and constants for the linked car chain table unit
// no dependencies
package lcct_pkg;

    localparam int CARS   = 64;
    localparam int NODE_W = 6;
    localparam int LINK_W = 7;
    localparam int LEN_W  = 7;

    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(64);

    localparam logic [1:0] FUNC_LINK   = 2'd0;
    localparam logic [1:0] FUNC_UNLINK = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } lcct_in_t;

    typedef struct packed {
        logic [NODE_W-1:0] member;
        logic [LEN_W-1:0]  chain_length;
        logic              last;
    } lcct_out_t;

    // request from the sequencer to the link table
    typedef struct packed {
        logic              wr_en;
        logic              wr_link;
        logic [NODE_W-1:0] wr_a;
        logic [NODE_W-1:0] wr_b;
        logic              rd_back;
        logic [NODE_W-1:0] rd_addr;
    } lcct_lt_req_t;

    // true when a link value names a node of the table
    function automatic logic in_range(logic [LINK_W-1:0] n);
        return n < LINK_W'(CARS);
    endfunction

endpackage

// ----- src/linked_car_chain_table_unit.sv -----
// Link and unlink items are written to the link table as they are accepted and busy
// never rises for them. A query walks the front links from the given node to the
// head and then the back links to the tail, each step waiting on the registered read
// of the link table; it then emits the chain head to tail, each member by a list
// buffer read and then output. Each member is shown for one cycle on result with
// result_valid high and cannot be held off; chain_length is the same on every
// member and last marks the tail. A query of a node out of range and func 3 give
// no results.
// depends on lcct_pkg, lcct_ram and lcct_link_table
module linked_car_chain_table_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lcct_pkg::lcct_in_t  cmd,
    output logic                result_valid,
    output lcct_pkg::lcct_out_t result
);
    import lcct_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FW_RD  = 3'd1;
    localparam logic [2:0] ST_FW_CHK = 3'd2;
    localparam logic [2:0] ST_BW_RD  = 3'd3;
    localparam logic [2:0] ST_BW_CHK = 3'd4;
    localparam logic [2:0] ST_EM_RD  = 3'd5;
    localparam logic [2:0] ST_EM_OUT = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] anode_reg, anode_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  nf_reg, nf_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic              accept;
    logic              a_ok;
    logic              b_ok;
    lcct_lt_req_t      lt_req;
    logic [LINK_W-1:0] link_q;
    logic              list_we;
    logic [NODE_W-1:0] list_waddr;
    logic [NODE_W-1:0] list_wdata;
    logic [NODE_W-1:0] list_raddr;
    logic [NODE_W-1:0] list_q;
    logic [LEN_W-1:0]  rev_idx;
    logic [LEN_W-1:0]  idx_inc;
    logic              is_last;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign a_ok   = in_range({1'b0, cmd.node_a});
    assign b_ok   = in_range({1'b0, cmd.node_b});

    assign idx_inc = idx_reg + LEN_W'(1);
    assign is_last = (idx_inc == cnt_reg);
    assign rev_idx = nf_reg - LEN_W'(1) - idx_reg;

    lcct_link_table u_links (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (lt_req),
        .rd_data (link_q)
    );

    // chain buffer: front walk in order found, back walk after it
    lcct_ram #(.WIDTH(NODE_W), .DEPTH(CARS)) u_list (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_q)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        anode_next = anode_reg;
        cnt_next   = cnt_reg;
        nf_next    = nf_reg;
        idx_next   = idx_reg;

        lt_req.wr_en   = 1'b0;
        lt_req.wr_link = (cmd.func == FUNC_LINK);
        lt_req.wr_a    = cmd.node_a;
        lt_req.wr_b    = cmd.node_b;
        lt_req.rd_back = 1'b0;
        lt_req.rd_addr = cur_reg;

        list_we    = 1'b0;
        list_waddr = cnt_reg[NODE_W-1:0];
        list_wdata = cur_reg;
        list_raddr = (idx_reg < nf_reg) ? rev_idx[NODE_W-1:0] : idx_reg[NODE_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd.func == FUNC_LINK || cmd.func == FUNC_UNLINK) && a_ok && b_ok)
                    begin
                        lt_req.wr_en = 1'b1;
                    end
                    else if (cmd.func == FUNC_QUERY && a_ok)
                    begin
                        cur_next   = cmd.node_a;
                        anode_next = cmd.node_a;
                        cnt_next   = '0;
                        state_next = ST_FW_RD;
                    end
                end
            end
            ST_FW_RD:
            begin
                // store this node, fetch its front link
                list_we    = 1'b1;
                cnt_next   = cnt_reg + LEN_W'(1);
                state_next = ST_FW_CHK;
            end
            ST_FW_CHK:
            begin
                if (cnt_reg == LEN_W'(CARS) || !in_range(link_q))
                begin
                    nf_next    = cnt_reg;
                    cur_next   = anode_reg;
                    state_next = ST_BW_RD;
                end
                else
                begin
                    cur_next   = link_q[NODE_W-1:0];
                    state_next = ST_FW_RD;
                end
            end
            ST_BW_RD:
            begin
                lt_req.rd_back = 1'b1;
                state_next     = ST_BW_CHK;
            end
            ST_BW_CHK:
            begin
                if (in_range(link_q) && cnt_reg < LEN_W'(CARS))
                begin
                    list_we    = 1'b1;
                    list_wdata = link_q[NODE_W-1:0];
                    cnt_next   = cnt_reg + LEN_W'(1);
                    cur_next   = link_q[NODE_W-1:0];
                    state_next = ST_BW_RD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_EM_RD;
                end
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                idx_next   = idx_inc;
                state_next = is_last ? ST_IDLE : ST_EM_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // walk and emit bookkeeping
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        anode_reg <= anode_next;
        cnt_reg   <= cnt_next;
        nf_reg    <= nf_next;
        idx_reg   <= idx_next;
    end

    // result item
    assign result_valid        = (state_reg == ST_EM_OUT);
    assign result.member       = list_q;
    assign result.chain_length = cnt_reg;
    assign result.last         = is_last;

endmodule

// ----- src/lcct_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module lcct_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/lcct_link_table.sv -----
// front and back link tables with per-entry valid bits
// depends on lcct_pkg and lcct_ram
module lcct_link_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lcct_pkg::lcct_lt_req_t     req,
    output logic [lcct_pkg::LINK_W-1:0] rd_data
);
    import lcct_pkg::*;

    logic [CARS-1:0]   front_vld_reg;
    logic [CARS-1:0]   back_vld_reg;
    logic              rd_back_reg;
    logic              rd_vld_reg;
    logic [LINK_W-1:0] front_q;
    logic [LINK_W-1:0] back_q;
    logic [LINK_W-1:0] wr_front_val;
    logic [LINK_W-1:0] wr_back_val;

    // link stores the partner, unlink stores the no-link mark
    assign wr_back_val  = req.wr_link ? {1'b0, req.wr_b} : NO_LINK;
    assign wr_front_val = req.wr_link ? {1'b0, req.wr_a} : NO_LINK;

    lcct_ram #(.WIDTH(LINK_W), .DEPTH(CARS)) u_front (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.wr_b),
        .wdata (wr_front_val),
        .raddr (req.rd_addr),
        .rdata (front_q)
    );

    lcct_ram #(.WIDTH(LINK_W), .DEPTH(CARS)) u_back (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.wr_a),
        .wdata (wr_back_val),
        .raddr (req.rd_addr),
        .rdata (back_q)
    );

    // valid bits, read alongside the ram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= '0;
            back_vld_reg  <= '0;
            rd_back_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                front_vld_reg[req.wr_b] <= 1'b1;
                back_vld_reg[req.wr_a]  <= 1'b1;
            end
            rd_back_reg <= req.rd_back;
            rd_vld_reg  <= req.rd_back ? back_vld_reg[req.rd_addr]
                                       : front_vld_reg[req.rd_addr];
        end
    end

    // an entry never written reads as no link
    always_comb
    begin
        if (!rd_vld_reg)
        begin
            rd_data = NO_LINK;
        end
        else if (rd_back_reg)
        begin
            rd_data = back_q;
        end
        else
        begin
            rd_data = front_q;
        end
    end

endmodule

// ----- src/lcct_checker.sv -----
// port-level checks for the linked car chain table unit, bound to the top level
// depends on lcct_pkg and linked_car_chain_table_unit_defines.svh
`include "linked_car_chain_table_unit_defines.svh"

module lcct_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input lcct_pkg::lcct_in_t  cmd,
    input logic                result_valid,
    input lcct_pkg::lcct_out_t result
);
    import lcct_pkg::*;

    logic query_acc;

    assign query_acc = start && !busy && (cmd.func == FUNC_QUERY)
                       && in_range({1'b0, cmd.node_a});

    // an accepted query in range occupies the block
    `LCCT_ASSERT_NEXT(a_query_busy, query_acc, busy)

    // results only appear while a query is running
    `LCCT_ASSERT_NOW(a_result_busy, result_valid, busy && result.chain_length != '0)

    // the tail ends the query
    `LCCT_ASSERT_NEXT(a_last_ends, result_valid && result.last, !result_valid && !busy)

    // members other than the tail are followed by a gap with the block still busy
    `LCCT_ASSERT_NEXT(a_member_gap, result_valid && !result.last, busy && !result_valid)

endmodule

bind linked_car_chain_table_unit lcct_checker u_lcct_checker (.*);

// ----- sim/linked_car_chain_table_unit_tb.sv -----
// testbench for linked_car_chain_table_unit: link, unlink and query items
// checked against an in-bench copy of the link tables; needs lcct_pkg
module linked_car_chain_table_unit_tb;
    import lcct_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_TIME  = 300;
    localparam int RANDOM_ITEMS = 320;
    localparam int CALM_TAIL    = 40;

    // code with no operation behind it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        lcct_in_t cmd;
        bit       wait_drain;
    } pending_cmd_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    lcct_in_t  cmd;
    logic      result_valid;
    lcct_out_t result;

    // bench copy of the link tables
    logic [LINK_W-1:0] front_ptr [CARS];
    logic [LINK_W-1:0] back_ptr  [CARS];

    pending_cmd_t cmd_backlog[$];
    lcct_out_t    expected_members[$];

    bit item_taken;
    int gap_left;
    int stall_cycles;
    int fail_count;

    linked_car_chain_table_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    always #HALF_PERIOD clk = ~clk;

    // update the bench tables and queue up the members a query should emit
    function automatic void apply_cmd(lcct_in_t c);
        logic [LINK_W-1:0] walk;
        logic [NODE_W-1:0] upstream[$];
        logic [NODE_W-1:0] members[$];
        lcct_out_t         r;
        case (c.func)
            FUNC_LINK:
            begin
                if (c.node_a < CARS && c.node_b < CARS)
                begin
                    back_ptr[c.node_a]  = {1'b0, c.node_b};
                    front_ptr[c.node_b] = {1'b0, c.node_a};
                end
            end
            FUNC_UNLINK:
            begin
                if (c.node_a < CARS && c.node_b < CARS)
                begin
                    back_ptr[c.node_a]  = NO_LINK;
                    front_ptr[c.node_b] = NO_LINK;
                end
            end
            FUNC_QUERY:
            begin
                if (c.node_a < CARS)
                begin
                    // towards the head, capped at one node per table entry
                    walk = {1'b0, c.node_a};
                    while (upstream.size() < CARS)
                    begin
                        upstream.push_front(walk[NODE_W-1:0]);
                        walk = front_ptr[walk[NODE_W-1:0]];
                        if (walk >= CARS)
                            break;
                    end
                    members = upstream;
                    // then towards the tail while room is left
                    walk = back_ptr[c.node_a];
                    while (walk < CARS && members.size() < CARS)
                    begin
                        members.insert(members.size(), walk[NODE_W-1:0]);
                        walk = back_ptr[walk[NODE_W-1:0]];
                    end
                    foreach (members[i])
                    begin
                        r.member       = members[i];
                        r.chain_length = LEN_W'(members.size());
                        r.last         = (i == members.size() - 1);
                        expected_members.insert(expected_members.size(), r);
                    end
                end
            end
            default:
            begin
                // unused code, nothing happens
            end
        endcase
    endfunction

    function automatic void push_cmd(logic [1:0] f, int a, int b, bit drain);
        pending_cmd_t p;
        p.cmd.func   = f;
        p.cmd.node_a = NODE_W'(a);
        p.cmd.node_b = NODE_W'(b);
        p.wait_drain = drain;
        cmd_backlog.insert(cmd_backlog.size(), p);
    endfunction

    // driver: new item or idle gap at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || item_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() == 0 ||
                         (cmd_backlog[0].wait_drain && expected_members.size() != 0))
                begin
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(1, 12) - 1;
                    start <= 1'b0;
                end
                else
                begin
                    cmd   <= cmd_backlog[0].cmd;
                    start <= 1'b1;
                    void'(cmd_backlog.pop_front());
                end
            end
        end
    end

    // monitor: acceptance, result checks and watchdog at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_taken = start && !busy;
            if (item_taken)
                apply_cmd(cmd);
            if (result_valid)
            begin
                if (expected_members.size() == 0)
                begin
                    $error("unexpected result: member %0d length %0d last %0d",
                           result.member, result.chain_length, result.last);
                    fail_count++;
                end
                else
                begin
                    if (result.member !== expected_members[0].member)
                    begin
                        $error("member: expected %0d, got %0d",
                               expected_members[0].member, result.member);
                        fail_count++;
                    end
                    if (result.chain_length !== expected_members[0].chain_length)
                    begin
                        $error("chain_length: expected %0d, got %0d",
                               expected_members[0].chain_length, result.chain_length);
                        fail_count++;
                    end
                    if (result.last !== expected_members[0].last)
                    begin
                        $error("last: expected %0d, got %0d",
                               expected_members[0].last, result.last);
                        fail_count++;
                    end
                    void'(expected_members.pop_front());
                end
            end
            if (item_taken || result_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("linked_car_chain_table_unit_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int order[CARS];
        int len;
        int k;
        int j;
        int tmp;
        int pick;
        bit drain;

        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        item_taken   = 1'b0;
        gap_left     = 0;
        stall_cycles = 0;
        fail_count   = 0;
        foreach (front_ptr[i])
        begin
            front_ptr[i] = NO_LINK;
            back_ptr[i]  = NO_LINK;
        end

        // directed: extremes, every operation, loops and stale links
        push_cmd(FUNC_LINK, 0, 1, 0);
        push_cmd(FUNC_LINK, 1, 2, 0);
        push_cmd(FUNC_LINK, 2, 63, 0);
        push_cmd(FUNC_QUERY, 1, 63, 0);
        push_cmd(FUNC_QUERY, 63, 0, 0);
        push_cmd(FUNC_QUERY, 0, 0, 0);
        push_cmd(FUNC_UNLINK, 1, 2, 0);
        push_cmd(FUNC_QUERY, 0, 63, 0);
        push_cmd(FUNC_QUERY, 2, 21, 0);
        // unlink of two nodes that were never joined
        push_cmd(FUNC_UNLINK, 10, 20, 0);
        push_cmd(FUNC_QUERY, 10, 42, 0);
        // self link gives a loop, capped at a full table
        push_cmd(FUNC_LINK, 5, 5, 0);
        push_cmd(FUNC_QUERY, 5, 0, 0);
        push_cmd(FUNC_UNUSED, 63, 63, 0);
        push_cmd(FUNC_UNUSED, 0, 0, 0);
        push_cmd(FUNC_LINK, 63, 0, 0);
        push_cmd(FUNC_QUERY, 0, 0, 0);
        // close a ring of four
        push_cmd(FUNC_LINK, 1, 2, 0);
        push_cmd(FUNC_QUERY, 63, 63, 0);
        push_cmd(FUNC_UNLINK, 5, 5, 0);
        push_cmd(FUNC_QUERY, 5, 42, 0);
        // second link onto the same back node leaves a stale back link
        push_cmd(FUNC_LINK, 40, 41, 0);
        push_cmd(FUNC_LINK, 39, 41, 0);
        push_cmd(FUNC_QUERY, 40, 0, 0);
        push_cmd(FUNC_QUERY, 41, 63, 0);

        // random: mostly chains built from shuffled nodes, then queried
        foreach (order[i])
            order[i] = i;
        drain = 1'b1;
        while (cmd_backlog.size() < RANDOM_ITEMS + 25)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                for (k = CARS - 1; k > 0; k--)
                begin
                    j        = $urandom_range(0, k);
                    tmp      = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, CARS)
                                                  : $urandom_range(2, 8);
                for (k = 0; k < len - 1; k++)
                begin
                    push_cmd(FUNC_LINK, order[k], order[k + 1], drain);
                    drain = 1'b0;
                end
                push_cmd(FUNC_QUERY, order[$urandom_range(0, len - 1)],
                         $urandom_range(0, 63), 0);
                if ($urandom_range(0, 1) == 1)
                begin
                    k = $urandom_range(0, len - 2);
                    push_cmd(FUNC_UNLINK, order[k], order[k + 1], 0);
                    push_cmd(FUNC_QUERY, order[$urandom_range(0, len - 1)],
                             $urandom_range(0, 63), 0);
                end
            end
            else if (pick < 9)
            begin
                push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 63), drain);
                drain = 1'b0;
            end
            else
            begin
                // hold the next item until the block has emptied
                drain = 1'b1;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every item to go in and every member to come out
        do
            @(negedge clk);
        while (!(cmd_backlog.size() == 0 && !start && expected_members.size() == 0));
        repeat (SETTLE_TIME) @(negedge clk);

        if (fail_count == 0)
            $display("linked_car_chain_table_unit_tb: done, clean");
        else
            $display("linked_car_chain_table_unit_tb: done, errors");
        $finish;
    end
endmodule
